FILE: sv/cfd_pkg.sv
// shared types and constants for the control frame decoder
// beat structs for both channels, status codes, register indexes, crc control
// no dependencies
package cfd_pkg;

  localparam int HDR_BYTES = 4;
  localparam int CRC_BYTES = 2;

  localparam logic [15:0] CRC_POLY     = 16'h1021;
  localparam logic [15:0] CRC_INIT_RST = 16'hFFFF;

  // configuration register indexes
  localparam logic [1:0] CFG_MAGIC    = 2'd0;
  localparam logic [1:0] CFG_VERSION  = 2'd1;
  localparam logic [1:0] CFG_CRC_INIT = 2'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_LEN     = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_BAD_CRC     = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_frame;
  } frame_beat_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] command;
    logic [6:0] payload_length;
    logic [7:0] payload_byte;
    logic [5:0] payload_index;
    logic       last_result;
  } report_beat_t;

  typedef struct packed {
    logic load_init;
    logic advance;
    logic shift;
    logic clear;
  } crc_ctl_t;

endpackage

FILE: sv/cfd_crc.sv
// crc16 datapath: running crc register and two-byte delay line
// depends on cfd_pkg
module cfd_crc (
  input  logic            clk,
  input  logic            rst,
  input  cfd_pkg::crc_ctl_t ctl,
  input  logic [7:0]      data_byte,
  input  logic [15:0]     crc_init,
  output logic [15:0]     crc_reg,
  output logic [15:0]     delay_pair
);
  import cfd_pkg::*;

  // one byte, msb first, no reflection
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int          i;
    c = crc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= CRC_INIT_RST;
      delay_pair <= '0;
    end else if (ctl.clear) begin
      delay_pair <= '0;
    end else if (ctl.shift) begin
      if (ctl.load_init) begin
        crc_reg <= crc_init;
      end else if (ctl.advance) begin
        crc_reg <= crc_step(crc_reg, delay_pair[15:8]);
      end
      delay_pair <= {delay_pair[7:0], data_byte};
    end
  end

endmodule

FILE: sv/cfd_payload_buf.sv
// payload buffer: one-port-write, one-port-read memory with registered read
// decodes the frame byte position into a store address; depends on cfd_pkg
module cfd_payload_buf #(
  parameter int MAX_PAYLOAD = 32,
  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  logic          clk,
  input  logic          wr_beat,
  input  logic [7:0]    pos,
  input  logic [7:0]    data_byte,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);
  import cfd_pkg::*;

  localparam logic [7:0] FirstPos = 8'(HDR_BYTES);
  localparam logic [7:0] EndPos   = 8'(HDR_BYTES + MAX_PAYLOAD);

  logic [7:0]    mem [MAX_PAYLOAD];
  logic [7:0]    offset;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  // bytes past the buffer end are dropped
  assign offset  = pos - FirstPos;
  assign wr_en   = wr_beat && (pos >= FirstPos) && (pos < EndPos);
  assign wr_addr = offset[AW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= data_byte;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/control_frame_decoder_unit.sv
// control frame decoder top level: byte receive, frame judgement, report sequencer
// depends on cfd_pkg, cfd_crc and cfd_payload_buf
//
// usage
//   frame channel: one frame byte per beat, end_of_frame set on the final byte.
//   bytes are taken at one per cycle while a frame is being received.
//   report channel: after the final byte the frame is judged (magic, version,
//   length, crc16 poly 0x1021 from crc_init) and reported: one beat with the
//   status, or for a good frame with payload one beat per payload byte.
//   after the final byte the judge state forms the verdict; the send state then
//   loads a status-only beat, or issues the first payload read and moves to the
//   show state, which loads the payload beats at one per cycle while the receiver
//   takes them, set by the single read port of the payload memory.
//   frame_ready drops from the final byte until the frame's last report beat sits
//   in the output register, through the judge, send and any show states.
//   the output register lets the next frame be received while the last report
//   beat still waits; a stalled receiver simply holds the report sequencer.
//   reset clears the control state and sets magic/version to 0 and crc_init to
//   0xffff; the payload memory needs no clearing pass.
//   configuration writes take effect at once; a new crc_init applies from the
//   next frame's first byte.
module control_frame_decoder_unit #(
  parameter int MAX_PAYLOAD = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  frame_valid,
  output logic                  frame_ready,
  input  cfd_pkg::frame_beat_t  frame_data,
  output logic                  report_valid,
  input  logic                  report_ready,
  output cfd_pkg::report_beat_t report_data,
  input  logic                  cfg_write,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);
  import cfd_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MinFrame = 8'(HDR_BYTES + CRC_BYTES);
  localparam logic [7:0] MaxFrame = 8'(HDR_BYTES + MAX_PAYLOAD + CRC_BYTES);
  localparam logic [7:0] MaxLen   = 8'(MAX_PAYLOAD);
  localparam logic [8:0] Overhead = 9'(HDR_BYTES + CRC_BYTES);

  typedef enum logic [1:0] {S_RX, S_JUDGE, S_SEND, S_SHOW} state_t;

  state_t     state;

  // configuration registers
  logic [7:0]  frame_magic;
  logic [7:0]  frame_version;
  logic [15:0] crc_init;

  // per-frame receive state
  logic [7:0]  byte_count;
  logic        magic_ok;
  logic        version_ok;
  logic [7:0]  command_hold;
  logic [7:0]  length_hold;

  // report state
  status_t     verdict;
  status_t     verdict_next;
  logic [7:0]  rep_cmd;
  logic [6:0]  rep_len;
  logic [5:0]  rd_idx;
  logic [5:0]  idx_inc;
  logic        last_item;

  logic        accept;
  logic        out_free;
  logic        load_beat;
  logic        rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]  rd_data;
  logic [15:0] crc_reg;
  logic [15:0] delay_pair;
  crc_ctl_t    crc_ctl;

  assign accept      = frame_valid && frame_ready;
  assign frame_ready = (state == S_RX);
  assign out_free    = !report_valid || report_ready;
  assign idx_inc     = rd_idx + 6'd1;
  assign last_item   = ({1'b0, rd_idx} + 7'd1) == rep_len;

  // output register takes a new beat: status-only beat in S_SEND, payload beat in S_SHOW
  assign load_beat = out_free &&
                     (((state == S_SEND) && !((verdict == ST_OK) && (rep_len != 7'd0))) ||
                      (state == S_SHOW));

  // crc runs two bytes behind, so at the final byte the delay holds the crc field
  assign crc_ctl.shift     = accept;
  assign crc_ctl.load_init = (byte_count == 8'd0);
  assign crc_ctl.advance   = (byte_count >= 8'd2);
  assign crc_ctl.clear     = (state == S_JUDGE);

  // first read goes out in S_SEND, each following one as the previous beat is loaded
  assign rd_en   = ((state == S_SEND) && (verdict == ST_OK) && (rep_len != 7'd0)) ||
                   ((state == S_SHOW) && out_free && !last_item);
  assign rd_addr = (state == S_SHOW) ? idx_inc[AW-1:0] : '0;

  cfd_crc u_crc (
    .clk        (clk),
    .rst        (rst),
    .ctl        (crc_ctl),
    .data_byte  (frame_data.data_byte),
    .crc_init   (crc_init),
    .crc_reg    (crc_reg),
    .delay_pair (delay_pair)
  );

  cfd_payload_buf #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_buf (
    .clk       (clk),
    .wr_beat   (accept),
    .pos       (byte_count),
    .data_byte (frame_data.data_byte),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  // frame judgement, checks in priority order
  always_comb begin
    if ((byte_count < MinFrame) || (byte_count > MaxFrame)) begin
      verdict_next = ST_BAD_LEN;
    end else if (!magic_ok) begin
      verdict_next = ST_BAD_MAGIC;
    end else if (!version_ok) begin
      verdict_next = ST_BAD_VERSION;
    end else if ((length_hold > MaxLen) ||
                 ({1'b0, byte_count} != ({1'b0, length_hold} + Overhead))) begin
      verdict_next = ST_BAD_LEN;
    end else if (crc_reg != delay_pair) begin
      verdict_next = ST_BAD_CRC;
    end else begin
      verdict_next = ST_OK;
    end
  end

  // configuration writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_magic   <= '0;
      frame_version <= '0;
      crc_init      <= CRC_INIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MAGIC:    frame_magic   <= cfg_data[7:0];
        CFG_VERSION:  frame_version <= cfg_data[7:0];
        CFG_CRC_INIT: crc_init      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_RX;
      byte_count   <= '0;
      magic_ok     <= 1'b0;
      version_ok   <= 1'b0;
      command_hold <= '0;
      length_hold  <= '0;
      verdict      <= ST_OK;
      report_valid <= 1'b0;
    end else begin
      if (load_beat) begin
        report_valid <= 1'b1;
      end else if (report_ready) begin
        report_valid <= 1'b0;
      end
      case (state)
        S_RX: begin
          if (accept) begin
            case (byte_count)
              8'd0:    magic_ok     <= (frame_data.data_byte == frame_magic);
              8'd1:    version_ok   <= (frame_data.data_byte == frame_version);
              8'd2:    command_hold <= frame_data.data_byte;
              8'd3:    length_hold  <= frame_data.data_byte;
              default: ;
            endcase
            // saturating count for overlong frames
            if (byte_count != 8'hFF) begin
              byte_count <= byte_count + 8'd1;
            end
            if (frame_data.end_of_frame) begin
              state <= S_JUDGE;
            end
          end
        end
        S_JUDGE: begin
          verdict      <= verdict_next;
          rep_cmd      <= command_hold;
          rep_len      <= length_hold[6:0];
          byte_count   <= '0;
          magic_ok     <= 1'b0;
          version_ok   <= 1'b0;
          command_hold <= '0;
          length_hold  <= '0;
          state        <= S_SEND;
        end
        S_SEND: begin
          if ((verdict == ST_OK) && (rep_len != 7'd0)) begin
            rd_idx <= '0;
            state  <= S_SHOW;
          end else if (out_free) begin
            // failed frame, or good frame without payload
            report_data.status         <= verdict;
            report_data.command        <= (verdict == ST_OK) ? rep_cmd : 8'h00;
            report_data.payload_length <= '0;
            report_data.payload_byte   <= '0;
            report_data.payload_index  <= '0;
            report_data.last_result    <= 1'b1;
            state                      <= S_RX;
          end
        end
        S_SHOW: begin
          if (out_free) begin
            report_data.status         <= ST_OK;
            report_data.command        <= rep_cmd;
            report_data.payload_length <= rep_len;
            report_data.payload_byte   <= rd_data;
            report_data.payload_index  <= rd_idx;
            report_data.last_result    <= last_item;
            if (last_item) begin
              state <= S_RX;
            end else begin
              rd_idx <= idx_inc;
            end
          end
        end
        default: state <= S_RX;
      endcase
    end
  end

  // final byte always stops intake for judgement
  a_eof_stops_intake: assert property (@(posedge clk) disable iff (rst)
    (frame_valid && frame_ready && frame_data.end_of_frame) |=> !frame_ready)
    else $error("intake not stopped after final byte");

  // per-frame state already cleared once the verdict is out
  a_frame_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEND) |-> (byte_count == 8'd0) && !magic_ok && !version_ok)
    else $error("frame state not cleared after judgement");

  // failed frames give a single empty beat
  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    (report_valid && (report_data.status != ST_OK)) |->
      report_data.last_result && (report_data.payload_length == 7'd0) &&
      (report_data.command == 8'h00))
    else $error("failed frame report malformed");

  // a non-final payload beat lies inside the payload
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (report_valid && !report_data.last_result) |->
      (({1'b0, report_data.payload_index} + 7'd1) < report_data.payload_length))
    else $error("payload index past payload length");

  // payload beats stream back to back with consecutive indexes
  a_idx_stream: assert property (@(posedge clk) disable iff (rst)
    (report_valid && report_ready && !report_data.last_result) |=>
      report_valid &&
      (report_data.payload_index == ($past(report_data.payload_index) + 6'd1)))
    else $error("payload beat missing or out of order");

endmodule
